// ===== rtl/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqs_pkg
// shared types and constants for the fifo queue with search
// ----------------------------------------------------------------------------
package fqs_pkg;

	// default ring depth and the cap on results of one dump
	localparam int DEPTH_DEF   = 16;
	localparam int MAX_RESULTS = 16;

	// field widths
	localparam int DATA_W   = 32;
	localparam int POS_W    = 4;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 3'd0,
		MODE_DELETE = 3'd1,
		MODE_SEARCH = 3'd2,
		MODE_PEEK   = 3'd3,
		MODE_DUMP   = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2,
		STATUS_MISS  = 2'd3
	} status_t;

endpackage

// ===== rtl/fqs_ram.sv =====
// ----------------------------------------------------------------------------
// fqs_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fqs_ram #(
	parameter int WIDTH = fqs_pkg::DATA_W,
	parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// read data holds while rd_en is low
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/fifo_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// bounded fifo of signed 32-bit values in a ring memory, with search and dump
// ----------------------------------------------------------------------------
// - input channel in_valid/in_ready carries mode and value; one operation per
//   transfer: insert, delete head, search, peek tail, dump all
// - output channel out_valid/out_ready carries status, data, position, last;
//   last marks the final result transfer of an operation
// - insert, and any operation on an empty queue, decide at once; the result
//   is then loaded through the emit state into the output register
// - delete and peek read one ring entry, which goes straight to the output
// - search reads one entry per cycle from the head and stops at the first hit,
//   reporting its position; a scan that ends without a hit reports a miss
// - dump offers one result per cycle from the head while the receiver accepts,
//   up to 16 results; the registered read port of the ring memory sets this pace
// - a new item is taken the cycle after the final result enters the output
//   register, so it overlaps a waiting result; no new item is taken while an
//   operation is still being worked on
// - reset empties the queue (head and count to zero); ring contents are left
//   as they were and are never read before being written
// - when the receiver stalls the output register holds, and a scan with a result
//   to load stops with its one outstanding read held in the memory output;
//   modes five to seven are taken and dropped with no result
// ----------------------------------------------------------------------------
module fifo_queue_with_search #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [fqs_pkg::MODE_W-1:0]          mode,
	input  logic signed [fqs_pkg::DATA_W-1:0]   value,
	// output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fqs_pkg::STATUS_W-1:0]        status,
	output logic signed [fqs_pkg::DATA_W-1:0]   data,
	output logic [fqs_pkg::POS_W-1:0]           position,
	output logic                                last
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// ring index of base + offset, both below DEPTH
	function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] ofs);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(ofs);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	state_t                        state_q;
	logic [IDX_W-1:0]              head_q;
	logic [CNT_W-1:0]              count_q;

	// operation being worked on
	fqs_pkg::mode_t                op_q;
	logic [fqs_pkg::DATA_W-1:0]    key_q;
	logic [IDX_W-1:0]              base_q;     // head at the start of the scan
	logic [CNT_W-1:0]              ofs_q;      // next offset to read
	logic [CNT_W-1:0]              end_q;      // one past the last offset
	fqs_pkg::status_t              res_q;      // pending single result

	// read in flight: memory output holds the entry at offset pos_s1
	logic                          pend_s1;
	logic [IDX_W-1:0]              pos_s1;

	// output register
	logic                          out_valid_q;
	fqs_pkg::status_t              status_q;
	logic [fqs_pkg::DATA_W-1:0]    data_q;
	logic [fqs_pkg::POS_W-1:0]     position_q;
	logic                          last_q;

	logic                          in_xfer;
	logic                          out_free;
	logic                          load_out;
	logic                          wr_en;
	logic [IDX_W-1:0]              wr_addr;
	logic                          rd_en;
	logic [IDX_W-1:0]              rd_addr;
	logic [fqs_pkg::DATA_W-1:0]    rd_data;
	logic                          hit;
	logic                          is_end;
	logic                          need_out;
	logic                          consume;
	logic                          done;
	logic                          is_search;
	logic                          full;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign full      = (count_q == CNT_W'(DEPTH));

	// inserts write in the transfer cycle; reads only come in later cycles
	// and never in the same cycle, so no forwarding is needed
	assign wr_en     = in_xfer && (mode == fqs_pkg::MODE_INSERT) && !full;
	assign wr_addr   = ring_idx(head_q, count_q);

	// scan control: one read outstanding, the next issued as the last drains
	assign is_search = (op_q == fqs_pkg::MODE_SEARCH);
	assign hit       = (rd_data == key_q);
	assign is_end    = ((CNT_W'(pos_s1) + CNT_W'(1)) == end_q);
	assign need_out  = pend_s1 && (!is_search || hit || is_end);
	assign consume   = (state_q == ST_SCAN) && pend_s1 && (!need_out || out_free);
	assign done      = consume && (is_end || (is_search && hit));
	assign rd_en     = (state_q == ST_SCAN) && (ofs_q != end_q) && !done
		&& (!pend_s1 || consume);
	assign rd_addr   = ring_idx(base_q, ofs_q);

	// a result enters the output register this cycle
	assign load_out  = ((state_q == ST_EMIT) && out_free) || (consume && need_out);

	fqs_ram #(
		.WIDTH (fqs_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			op_q        <= fqs_pkg::MODE_INSERT;
			key_q       <= '0;
			base_q      <= '0;
			ofs_q       <= '0;
			end_q       <= '0;
			res_q       <= fqs_pkg::STATUS_OK;
			pend_s1     <= 1'b0;
			pos_s1      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= fqs_pkg::STATUS_OK;
			data_q      <= '0;
			position_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			// output register loads a result or drains on its transfer
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						op_q   <= fqs_pkg::mode_t'(mode);
						key_q  <= value;
						base_q <= head_q;
						unique case (mode)
							fqs_pkg::MODE_INSERT: begin
								if (full) begin
									res_q <= fqs_pkg::STATUS_FULL;
								end else begin
									res_q   <= fqs_pkg::STATUS_OK;
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= ST_EMIT;
							end
							fqs_pkg::MODE_DELETE,
							fqs_pkg::MODE_SEARCH,
							fqs_pkg::MODE_PEEK,
							fqs_pkg::MODE_DUMP: begin
								if (count_q == '0) begin
									res_q   <= fqs_pkg::STATUS_EMPTY;
									state_q <= ST_EMIT;
								end else begin
									state_q <= ST_SCAN;
									unique case (mode)
										fqs_pkg::MODE_DELETE: begin
											ofs_q   <= '0;
											end_q   <= CNT_W'(1);
											head_q  <= ring_idx(head_q, CNT_W'(1));
											count_q <= count_q - CNT_W'(1);
										end
										fqs_pkg::MODE_PEEK: begin
											ofs_q <= count_q - CNT_W'(1);
											end_q <= count_q;
										end
										fqs_pkg::MODE_DUMP: begin
											ofs_q <= '0;
											// a dump stops at the result cap
											if (int'(count_q) > fqs_pkg::MAX_RESULTS) begin
												end_q <= CNT_W'(fqs_pkg::MAX_RESULTS);
											end else begin
												end_q <= count_q;
											end
										end
										default: begin
											ofs_q <= '0;
											end_q <= count_q;
										end
									endcase
								end
							end
							default: begin
								// unused modes: dropped, no result
							end
						endcase
					end
				end

				ST_EMIT: begin
					if (out_free) begin
						status_q    <= res_q;
						data_q      <= '0;
						position_q  <= '0;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				ST_SCAN: begin
					if (rd_en) begin
						pend_s1 <= 1'b1;
						pos_s1  <= ofs_q[IDX_W-1:0];
						ofs_q   <= ofs_q + CNT_W'(1);
					end else if (consume) begin
						pend_s1 <= 1'b0;
					end
					if (consume && need_out) begin
						last_q      <= done;
						if (is_search && !hit) begin
							status_q   <= fqs_pkg::STATUS_MISS;
							data_q     <= '0;
							position_q <= '0;
						end else begin
							status_q <= fqs_pkg::STATUS_OK;
							data_q   <= rd_data;
							if (is_search || (op_q == fqs_pkg::MODE_DUMP)) begin
								position_q <= fqs_pkg::POS_W'(pos_s1);
							end else begin
								position_q <= '0;
							end
						end
					end
					if (done) begin
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign position  = position_q;
	assign last      = last_q;

endmodule

// ===== tb/tb_fifo_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_search
// self-checking bench: a queue predictor in a small scoreboard class works out
// the results of every accepted operation and checks each result transfer in
// order. a directed opening covers empty, extreme and duplicate cases, then
// random fill and drain sweeps with random idling on both channels
// ----------------------------------------------------------------------------

class queue_predictor;

	typedef struct packed {
		fqs_pkg::status_t            st;
		logic signed [31:0]          dat;
		logic [fqs_pkg::POS_W-1:0]   pos;
		logic                        lst;
	} result_t;

	logic signed [31:0] ring [fqs_pkg::DEPTH_DEF];
	int unsigned        head;
	int unsigned        count;
	result_t            pending_results [$];
	int unsigned        results_taken;
	int unsigned        mismatches;

	function new();
		head          = 0;
		count         = 0;
		results_taken = 0;
		mismatches    = 0;
		foreach (ring[i])
			ring[i] = '0;
	endfunction

	function void expect_result(fqs_pkg::status_t st, logic signed [31:0] d,
			int unsigned p, bit l);
		result_t r;
		r.st  = st;
		r.dat = d;
		r.pos = p[fqs_pkg::POS_W-1:0];
		r.lst = l;
		pending_results.push_back(r);
	endfunction

	function logic signed [31:0] entry_at(int unsigned offset);
		return ring[(head + offset) % fqs_pkg::DEPTH_DEF];
	endfunction

	// note one accepted operation and queue up what it must produce
	function void apply_op(logic [fqs_pkg::MODE_W-1:0] op, logic signed [31:0] v);
		int unsigned n;
		if (op > fqs_pkg::MODE_DUMP)
			return;
		if (op == fqs_pkg::MODE_INSERT) begin
			if (count >= fqs_pkg::DEPTH_DEF) begin
				expect_result(fqs_pkg::STATUS_FULL, '0, 0, 1'b1);
			end else begin
				ring[(head + count) % fqs_pkg::DEPTH_DEF] = v;
				count++;
				expect_result(fqs_pkg::STATUS_OK, '0, 0, 1'b1);
			end
			return;
		end
		if (count == 0) begin
			expect_result(fqs_pkg::STATUS_EMPTY, '0, 0, 1'b1);
			return;
		end
		case (op)
			fqs_pkg::MODE_DELETE: begin
				expect_result(fqs_pkg::STATUS_OK, entry_at(0), 0, 1'b1);
				head = (head + 1) % fqs_pkg::DEPTH_DEF;
				count--;
			end
			fqs_pkg::MODE_SEARCH: begin
				for (int unsigned i = 0; i < count; i++) begin
					if (entry_at(i) == v) begin
						expect_result(fqs_pkg::STATUS_OK, v, i, 1'b1);
						return;
					end
				end
				expect_result(fqs_pkg::STATUS_MISS, '0, 0, 1'b1);
			end
			fqs_pkg::MODE_PEEK: begin
				expect_result(fqs_pkg::STATUS_OK, entry_at(count - 1), 0, 1'b1);
			end
			default: begin
				n = (count > fqs_pkg::MAX_RESULTS) ? fqs_pkg::MAX_RESULTS : count;
				for (int unsigned i = 0; i < n; i++)
					expect_result(fqs_pkg::STATUS_OK, entry_at(i), i, i + 1 == n);
			end
		endcase
	endfunction

	task report_mismatch(string what);
		if (mismatches < 40)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	task check_result(logic [1:0] st, logic signed [31:0] d, logic [3:0] p, logic l);
		result_t e;
		results_taken++;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result st=%0d data=%0d pos=%0d last=%0d",
				st, d, p, l));
			return;
		end
		e = pending_results.pop_front();
		if (st !== e.st)
			report_mismatch($sformatf("status %0d, expected %0d", st, e.st));
		if (d !== e.dat)
			report_mismatch($sformatf("data %0d, expected %0d", d, e.dat));
		if (p !== e.pos)
			report_mismatch($sformatf("position %0d, expected %0d", p, e.pos));
		if (l !== e.lst)
			report_mismatch($sformatf("last %0d, expected %0d", l, e.lst));
	endtask

endclass

module tb_fifo_queue_with_search;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_ready;
	logic [fqs_pkg::MODE_W-1:0]          mode;
	logic signed [fqs_pkg::DATA_W-1:0]   value;
	logic                                out_valid;
	logic                                out_ready;
	logic [fqs_pkg::STATUS_W-1:0]        status;
	logic signed [fqs_pkg::DATA_W-1:0]   data;
	logic [fqs_pkg::POS_W-1:0]           position;
	logic                                last;

	queue_predictor sb;

	fifo_queue_with_search u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data      (data),
		.position  (position),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop, well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("tb_fifo_queue_with_search: FAIL");
		$finish;
	end

	// offer one operation from a falling edge and hold it until the transfer;
	// returns on the following falling edge
	task automatic send_op(logic [fqs_pkg::MODE_W-1:0] m,
			logic signed [fqs_pkg::DATA_W-1:0] v);
		in_valid <= 1'b1;
		mode     <= m;
		value    <= v;
		do
			@(posedge clk);
		while (!in_ready);
		sb.apply_op(m, v);
		@(negedge clk);
	endtask

	// values for insert and search: extremes, a narrow band for duplicates,
	// and full-width random words so every bit toggles
	function automatic logic signed [fqs_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			3, 4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// receiver: random ready with short and long stalls, a few stretches of
	// steady acceptance, and one long hold-off that backs the block up
	initial begin
		int  stall;
		bit  held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held && sb.results_taken >= 30) begin
				// long hold-off, sender keeps offering meanwhile
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
			end else if ((sb.results_taken % 60) < 15) begin
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 9) < 7) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
					: $urandom_range(10, 30);
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// result monitor, sampled on the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, data, position, last);
	end

	// stimulus
	initial begin
		int unsigned                       taken;
		int unsigned                       gap;
		int unsigned                       r;
		bit                                filling;
		logic [fqs_pkg::MODE_W-1:0]        m;
		logic signed [fqs_pkg::DATA_W-1:0] v;

		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = '0;
		value     = '0;
		out_ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed opening: every operation on an empty queue
		send_op(fqs_pkg::MODE_DELETE, 32'sd0);
		send_op(fqs_pkg::MODE_SEARCH, 32'sh7fff_ffff);
		send_op(fqs_pkg::MODE_PEEK,   32'sd0);
		send_op(fqs_pkg::MODE_DUMP,   32'sd0);
		// unused modes are swallowed with no result
		send_op(3'd5, 32'sd0);
		send_op(3'd7, -32'sd1);
		// extremes, with one duplicate
		send_op(fqs_pkg::MODE_INSERT, 32'sh8000_0000);
		send_op(fqs_pkg::MODE_INSERT, 32'sh7fff_ffff);
		send_op(fqs_pkg::MODE_INSERT, -32'sd1);
		send_op(fqs_pkg::MODE_INSERT, 32'sh7fff_ffff);
		send_op(fqs_pkg::MODE_INSERT, 32'sd0);
		send_op(fqs_pkg::MODE_PEEK,   32'sd0);
		// duplicate hit reports the entry nearest the head
		send_op(fqs_pkg::MODE_SEARCH, 32'sh7fff_ffff);
		send_op(fqs_pkg::MODE_SEARCH, -32'sd1);
		send_op(fqs_pkg::MODE_SEARCH, 32'sh8000_0000);
		send_op(fqs_pkg::MODE_SEARCH, 32'sd12345);
		send_op(fqs_pkg::MODE_DUMP,   32'sd0);
		send_op(fqs_pkg::MODE_DELETE, 32'sd0);
		send_op(fqs_pkg::MODE_DELETE, 32'sd0);
		send_op(fqs_pkg::MODE_PEEK,   32'sd0);
		send_op(3'd6, 32'sh5555_aaaa);
		send_op(fqs_pkg::MODE_DUMP,   32'sd0);

		// random part: alternate fill and drain sweeps so the ring wraps and
		// reaches both full and empty, with noise mixed in
		filling = 1'b1;
		taken   = 0;
		while (taken < 108) begin
			if (sb.count == fqs_pkg::DEPTH_DEF && $urandom_range(0, 2) == 0)
				filling = 1'b0;
			else if (sb.count == 0)
				filling = 1'b1;

			r = $urandom_range(0, 99);
			if (r < 4) begin
				m = fqs_pkg::MODE_W'($urandom_range(5, 7));
			end else if (filling ? (r < 70) : (r < 12)) begin
				m = fqs_pkg::MODE_INSERT;
			end else if (!filling && r < 65) begin
				m = fqs_pkg::MODE_DELETE;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: m = fqs_pkg::MODE_SEARCH;
					4, 5:       m = fqs_pkg::MODE_PEEK;
					6, 7:       m = fqs_pkg::MODE_DELETE;
					default:    m = fqs_pkg::MODE_DUMP;
				endcase
			end

			// searches mostly aim at a stored value so hits land at every position
			if (m == fqs_pkg::MODE_SEARCH && sb.count > 0 && $urandom_range(0, 9) < 6)
				v = sb.entry_at($urandom_range(0, sb.count - 1));
			else
				v = pick_value();

			// sender gaps: a steady window every forty items, otherwise random
			if ((taken % 40) < 12)
				gap = 0;
			else if ($urandom_range(0, 9) < 6)
				gap = 0;
			else if ($urandom_range(0, 9) < 8)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(10, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end

			send_op(m, v);
			if (m <= fqs_pkg::MODE_DUMP)
				taken++;
		end
		in_valid <= 1'b0;

		// drain, then allow for a late spurious transfer
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("tb_fifo_queue_with_search: PASS");
		else
			$display("tb_fifo_queue_with_search: FAIL");
		$finish;
	end

endmodule
